// File: hdl/coma_pkg.sv
// shared types and constants for the center of mass accumulator
// widths of the atom fields, accumulators and divider, result status codes
// no dependencies
`default_nettype none

package coma_pkg;

	localparam int MASS_W    = 16;
	localparam int POS_W     = 24;
	localparam int TOT_W     = 32;
	localparam int SUM_W     = 56;
	localparam int PROD_W    = POS_W + MASS_W + 1;
	localparam int AXES      = 3;
	localparam int DIV_STEPS = SUM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [SUM_W-1:0] SAT_POS = SUM_W'(2**(POS_W-1) - 1);
	localparam logic [SUM_W-1:0] SAT_NEG = SUM_W'(2**(POS_W-1));

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [1:0] STATUS_ZERO_MASS = 2'd2;

	typedef struct packed {
		logic       load;
		logic       start_div;
		logic       step_div;
		logic       finish;
		logic [1:0] status;
	} cmd_t;

	typedef struct packed {
		logic any_seen;
		logic mass_zero;
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

// File: hdl/coma_datapath.sv
// datapath: product stage, mass and weighted sum accumulators,
// three bit-serial restoring dividers with rounding and saturation, result registers
// depends on coma_pkg
`default_nettype none

module coma_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  var coma_pkg::cmd_t               cmd,
	output coma_pkg::sts_t                   sts,
	input  wire                              has_atom,
	input  wire [coma_pkg::MASS_W-1:0]       atom_mass,
	input  wire signed [coma_pkg::POS_W-1:0] pos_x,
	input  wire signed [coma_pkg::POS_W-1:0] pos_y,
	input  wire signed [coma_pkg::POS_W-1:0] pos_z,
	output logic signed [coma_pkg::POS_W-1:0] center_x,
	output logic signed [coma_pkg::POS_W-1:0] center_y,
	output logic signed [coma_pkg::POS_W-1:0] center_z,
	output logic [1:0]                       result_status
);

	logic signed [coma_pkg::POS_W-1:0]  pos_in [coma_pkg::AXES];

	logic                               has_s1;
	logic [coma_pkg::MASS_W-1:0]        mass_s1;
	logic signed [coma_pkg::PROD_W-1:0] prod_s1 [coma_pkg::AXES];

	logic [coma_pkg::TOT_W-1:0]         mass_total_q;
	logic [coma_pkg::SUM_W-1:0]         sum_q [coma_pkg::AXES];
	logic                               any_q;

	logic [coma_pkg::SUM_W-1:0]         num_q [coma_pkg::AXES];
	logic [coma_pkg::TOT_W-1:0]         rem_q [coma_pkg::AXES];
	logic                               neg_q [coma_pkg::AXES];
	logic [coma_pkg::CNT_W-1:0]         cnt_q;

	logic [coma_pkg::SUM_W-1:0]         num_init [coma_pkg::AXES];
	logic [coma_pkg::TOT_W:0]           trial [coma_pkg::AXES];
	logic [coma_pkg::TOT_W+1:0]         diff [coma_pkg::AXES];
	logic                               ge [coma_pkg::AXES];
	logic [coma_pkg::POS_W-1:0]         mag [coma_pkg::AXES];
	logic [coma_pkg::POS_W-1:0]         sat [coma_pkg::AXES];

	logic [coma_pkg::POS_W-1:0]         center_q [coma_pkg::AXES];

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_s1 <= 1'b0;
		end else begin
			has_s1 <= cmd.load && has_atom;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mass_s1 <= atom_mass;
			for (int i = 0; i < coma_pkg::AXES; i++) begin
				prod_s1[i] <= pos_in[i] * $signed({1'b0, atom_mass});
			end
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_total_q <= '0;
			any_q        <= 1'b0;
			for (int i = 0; i < coma_pkg::AXES; i++) begin
				sum_q[i] <= '0;
			end
		end else if (cmd.finish) begin
			mass_total_q <= '0;
			any_q        <= 1'b0;
			for (int i = 0; i < coma_pkg::AXES; i++) begin
				sum_q[i] <= '0;
			end
		end else if (has_s1) begin
			mass_total_q <= mass_total_q + coma_pkg::TOT_W'(mass_s1);
			any_q        <= 1'b1;
			for (int i = 0; i < coma_pkg::AXES; i++) begin
				sum_q[i] <= sum_q[i] + coma_pkg::SUM_W'(prod_s1[i]);
			end
		end
	end

	// divider lanes
	always_comb begin
		for (int i = 0; i < coma_pkg::AXES; i++) begin
			// magnitude plus half the divisor, rounds half away from zero
			num_init[i] = (sum_q[i][coma_pkg::SUM_W-1] ? ~sum_q[i] : sum_q[i])
				+ coma_pkg::SUM_W'(mass_total_q[coma_pkg::TOT_W-1:1])
				+ coma_pkg::SUM_W'(sum_q[i][coma_pkg::SUM_W-1]);
			trial[i] = {rem_q[i], num_q[i][coma_pkg::SUM_W-1]};
			diff[i]  = {1'b0, trial[i]} - {2'b00, mass_total_q};
			ge[i]    = !diff[i][coma_pkg::TOT_W+1];
			if (neg_q[i]) begin
				mag[i] = (num_q[i] > coma_pkg::SAT_NEG) ?
					coma_pkg::SAT_NEG[coma_pkg::POS_W-1:0] : num_q[i][coma_pkg::POS_W-1:0];
				sat[i] = {coma_pkg::POS_W{1'b0}} - mag[i];
			end else begin
				mag[i] = (num_q[i] > coma_pkg::SAT_POS) ?
					coma_pkg::SAT_POS[coma_pkg::POS_W-1:0] : num_q[i][coma_pkg::POS_W-1:0];
				sat[i] = mag[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < coma_pkg::AXES; i++) begin
			if (cmd.start_div) begin
				num_q[i] <= num_init[i];
				rem_q[i] <= '0;
				neg_q[i] <= sum_q[i][coma_pkg::SUM_W-1];
			end else if (cmd.step_div) begin
				rem_q[i] <= ge[i] ? diff[i][coma_pkg::TOT_W-1:0] : trial[i][coma_pkg::TOT_W-1:0];
				num_q[i] <= {num_q[i][coma_pkg::SUM_W-2:0], ge[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start_div) begin
			cnt_q <= '0;
		end else if (cmd.step_div) begin
			cnt_q <= cnt_q + coma_pkg::CNT_W'(1);
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_status <= cmd.status;
			for (int i = 0; i < coma_pkg::AXES; i++) begin
				center_q[i] <= (cmd.status == coma_pkg::STATUS_OK) ? sat[i] : '0;
			end
		end
	end

	assign center_x = center_q[0];
	assign center_y = center_q[1];
	assign center_z = center_q[2];

	assign sts.any_seen  = any_q;
	assign sts.mass_zero = (mass_total_q == '0);
	assign sts.div_last  = (cnt_q == coma_pkg::CNT_W'(coma_pkg::DIV_STEPS - 1));

endmodule

`default_nettype wire

// File: hdl/coma_ctrl.sv
// controller: accepts atoms, sequences drain, divide and result load,
// holds the output valid flag
// depends on coma_pkg
`default_nettype none

module coma_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire                last_atom,
	input  wire                out_ready,
	input  var coma_pkg::sts_t sts,
	output logic               in_ready,
	output logic               out_valid,
	output coma_pkg::cmd_t     cmd
);

	localparam logic [2:0] S_ACC   = 3'd0;
	localparam logic [2:0] S_DRAIN = 3'd1;
	localparam logic [2:0] S_PREP  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] status_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_ACC);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load      = in_valid && in_ready;
		cmd.start_div = (state_q == S_PREP) && sts.any_seen && !sts.mass_zero;
		cmd.step_div  = (state_q == S_DIV);
		cmd.finish    = (state_q == S_FIN) && (!out_valid_q || out_ready);
		cmd.status    = status_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_ACC: begin
				if (cmd.load && last_atom) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_PREP;
			end
			S_PREP: begin
				state_d = cmd.start_div ? S_DIV : S_FIN;
			end
			S_DIV: begin
				if (sts.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (cmd.finish) begin
					state_d = S_ACC;
				end
			end
			default: begin
				state_d = S_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			status_q    <= coma_pkg::STATUS_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PREP) begin
				if (!sts.any_seen) begin
					status_q <= coma_pkg::STATUS_EMPTY;
				end else if (sts.mass_zero) begin
					status_q <= coma_pkg::STATUS_ZERO_MASS;
				end else begin
					status_q <= coma_pkg::STATUS_OK;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && last_atom) |=> !in_ready)
		else $error("input accepted right after closing transfer");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_last) |=> (state_q == S_FIN))
		else $error("divider did not hand over to result load");

	a_div_needs_mass: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |-> (sts.any_seen && !sts.mass_zero))
		else $error("division started without mass");
`endif

endmodule

`default_nettype wire

// File: hdl/center_of_mass_accumulator_core.sv
// top level of the center of mass accumulator
// depends on coma_pkg, coma_ctrl, coma_datapath
`default_nettype none

// Takes one atom transfer per clock while accumulating (mass unsigned Q8.8,
// x/y/z signed Q15.8) and sums mass and mass-weighted coordinates. A
// transfer with last_atom set closes the selection: input stalls while the
// sums settle, three one-bit-per-cycle restoring dividers run 56 steps and
// the result is loaded once any earlier result has been taken; with an
// empty selection or zero total mass the dividers are skipped. The result
// is rounded half away from zero and saturated to 24 bits; a finished result
// waits in the output register while the next selection is accumulated.
module center_of_mass_accumulator_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire                               has_atom,
	input  wire [coma_pkg::MASS_W-1:0]        atom_mass,
	input  wire signed [coma_pkg::POS_W-1:0]  pos_x,
	input  wire signed [coma_pkg::POS_W-1:0]  pos_y,
	input  wire signed [coma_pkg::POS_W-1:0]  pos_z,
	input  wire                               last_atom,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic signed [coma_pkg::POS_W-1:0] center_x,
	output logic signed [coma_pkg::POS_W-1:0] center_y,
	output logic signed [coma_pkg::POS_W-1:0] center_z,
	output logic [1:0]                        result_status
);

	coma_pkg::cmd_t cmd;
	coma_pkg::sts_t sts;

	coma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_atom (last_atom),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	coma_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.has_atom      (has_atom),
		.atom_mass     (atom_mass),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.center_x      (center_x),
		.center_y      (center_y),
		.center_z      (center_z),
		.result_status (result_status)
	);

endmodule

`default_nettype wire

// File: verif/center_of_mass_accumulator_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for center_of_mass_accumulator_core
// directed table, one long heavy selection, then random selections under random idling
// depends on coma_pkg and the core RTL

module center_of_mass_accumulator_core_tb;

	localparam int RANDOM_ITEMS   = 1730;
	localparam int LONG_SEL_ATOMS = 200;
	localparam int HOLD_CYCLES    = 1500;
	localparam int STALL_LIMIT    = 10000;
	localparam int SETTLE_CYCLES  = 100;

	typedef struct packed {
		bit                          has_atom;
		logic [coma_pkg::MASS_W-1:0] mass;
		logic [coma_pkg::POS_W-1:0]  x;
		logic [coma_pkg::POS_W-1:0]  y;
		logic [coma_pkg::POS_W-1:0]  z;
		bit                          last;
	} atom_t;

	typedef struct packed {
		logic [coma_pkg::POS_W-1:0] x;
		logic [coma_pkg::POS_W-1:0] y;
		logic [coma_pkg::POS_W-1:0] z;
		logic [1:0]                 status;
	} center_t;

	typedef enum bit {BY_MODEL, BY_VALUE} check_t;

	typedef struct packed {
		atom_t   atom;
		check_t  how;
		center_t want;
	} row_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic                               has_atom;
	logic [coma_pkg::MASS_W-1:0]        atom_mass;
	logic signed [coma_pkg::POS_W-1:0]  pos_x;
	logic signed [coma_pkg::POS_W-1:0]  pos_y;
	logic signed [coma_pkg::POS_W-1:0]  pos_z;
	logic                               last_atom;
	logic                               out_valid;
	logic                               out_ready;
	logic signed [coma_pkg::POS_W-1:0]  center_x;
	logic signed [coma_pkg::POS_W-1:0]  center_y;
	logic signed [coma_pkg::POS_W-1:0]  center_z;
	logic [1:0]                         result_status;

	// centroid predictor state
	logic [coma_pkg::TOT_W-1:0] mass_sum;
	logic [coma_pkg::SUM_W-1:0] moment_x;
	logic [coma_pkg::SUM_W-1:0] moment_y;
	logic [coma_pkg::SUM_W-1:0] moment_z;
	bit                         atoms_in_sel;
	center_t                    pending_centers[$];

	int errors;
	int burst_left;
	bit steady;
	bit hold_request;
	int idle_cycles;

	center_of_mass_accumulator_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.has_atom(has_atom),
		.atom_mass(atom_mass),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.last_atom(last_atom),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z),
		.result_status(result_status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic atom_t make_atom(bit h, logic [coma_pkg::MASS_W-1:0] m,
			logic [coma_pkg::POS_W-1:0] x, logic [coma_pkg::POS_W-1:0] y,
			logic [coma_pkg::POS_W-1:0] z, bit l);
		atom_t a;
		a.has_atom = h;
		a.mass = m;
		a.x = x;
		a.y = y;
		a.z = z;
		a.last = l;
		return a;
	endfunction

	function automatic row_t plan_row(atom_t a, check_t how = BY_MODEL,
			logic [coma_pkg::POS_W-1:0] cx = '0, logic [coma_pkg::POS_W-1:0] cy = '0,
			logic [coma_pkg::POS_W-1:0] cz = '0, logic [1:0] st = coma_pkg::STATUS_OK);
		row_t r;
		r.atom = a;
		r.how = how;
		r.want.x = cx;
		r.want.y = cy;
		r.want.z = cz;
		r.want.status = st;
		return r;
	endfunction

	function automatic logic [coma_pkg::SUM_W-1:0] add_moment(logic [coma_pkg::SUM_W-1:0] acc,
			logic [coma_pkg::POS_W-1:0] pos, logic [coma_pkg::MASS_W-1:0] m);
		longint p;
		longint w;
		p = longint'($signed(pos));
		w = longint'(m);
		return acc + coma_pkg::SUM_W'(p * w);
	endfunction

	// quotient rounded half away from zero, saturated to 24 bits
	function automatic logic [coma_pkg::POS_W-1:0] rounded_coord(
			logic [coma_pkg::SUM_W-1:0] acc, logic [coma_pkg::TOT_W-1:0] total);
		longint s;
		longint unsigned mag;
		longint unsigned t;
		longint unsigned q;
		s = longint'($signed(acc));
		t = total;
		mag = (s < 0) ? -s : s;
		q = (mag + t / 2) / t;
		if (s < 0) begin
			if (q > 64'h800000)
				q = 64'h800000;
			return coma_pkg::POS_W'(-q);
		end
		if (q > 64'h7FFFFF)
			q = 64'h7FFFFF;
		return coma_pkg::POS_W'(q);
	endfunction

	function automatic bit predict_centroid(atom_t a, output center_t c);
		c = '0;
		if (a.has_atom) begin
			mass_sum = mass_sum + coma_pkg::TOT_W'(a.mass);
			moment_x = add_moment(moment_x, a.x, a.mass);
			moment_y = add_moment(moment_y, a.y, a.mass);
			moment_z = add_moment(moment_z, a.z, a.mass);
			atoms_in_sel = 1'b1;
		end
		if (!a.last)
			return 1'b0;
		if (!atoms_in_sel) begin
			c.status = coma_pkg::STATUS_EMPTY;
		end else if (mass_sum == '0) begin
			c.status = coma_pkg::STATUS_ZERO_MASS;
		end else begin
			c.x = rounded_coord(moment_x, mass_sum);
			c.y = rounded_coord(moment_y, mass_sum);
			c.z = rounded_coord(moment_z, mass_sum);
			c.status = coma_pkg::STATUS_OK;
		end
		mass_sum = '0;
		moment_x = '0;
		moment_y = '0;
		moment_z = '0;
		atoms_in_sel = 1'b0;
		return 1'b1;
	endfunction

	// called right after a rising edge; returns at the edge that takes the transfer
	task automatic send_atom(atom_t a, check_t how = BY_MODEL, center_t want = '0);
		int gap;
		center_t c;
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		has_atom <= a.has_atom;
		atom_mass <= a.mass;
		pos_x <= a.x;
		pos_y <= a.y;
		pos_z <= a.z;
		last_atom <= a.last;
		do @(posedge clk); while (!in_ready);
		if (predict_centroid(a, c))
			pending_centers.push_back(how == BY_VALUE ? want : c);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_centers.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [coma_pkg::POS_W-1:0] pick_pos();
		case ($urandom_range(0, 7))
			0: begin
				return 24'h7FFFFF;
			end
			1: begin
				return 24'h800000;
			end
			2, 3: begin
				return coma_pkg::POS_W'($urandom_range(0, 511)) - 24'd256;
			end
			default: begin
				return coma_pkg::POS_W'($urandom);
			end
		endcase
	endfunction

	function automatic logic [coma_pkg::MASS_W-1:0] pick_mass();
		case ($urandom_range(0, 15))
			0: begin
				return '0;
			end
			1: begin
				return 16'hFFFF;
			end
			2, 3: begin
				return coma_pkg::MASS_W'($urandom_range(1, 16));
			end
			default: begin
				return coma_pkg::MASS_W'($urandom);
			end
		endcase
	endfunction

	task automatic random_selection(inout int sent);
		int n;
		bit massless;
		bit bare_close;
		atom_t a;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
		if ($urandom_range(0, 19) == 0)
			n = 0;
		massless = ($urandom_range(0, 14) == 0);
		bare_close = (n == 0) || ($urandom_range(0, 7) == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				send_atom(make_atom(1'b0, coma_pkg::MASS_W'($urandom),
					coma_pkg::POS_W'($urandom), coma_pkg::POS_W'($urandom),
					coma_pkg::POS_W'($urandom), 1'b0));
				sent++;
			end
			a = make_atom(1'b1, massless ? '0 : pick_mass(), pick_pos(), pick_pos(), pick_pos(),
				!bare_close && i == n - 1);
			send_atom(a);
			sent++;
		end
		if (bare_close) begin
			send_atom(make_atom(1'b0, coma_pkg::MASS_W'($urandom), coma_pkg::POS_W'($urandom),
				coma_pkg::POS_W'($urandom), coma_pkg::POS_W'($urandom), 1'b1));
			sent++;
		end
	endtask

	// receiver: rotating ready pattern, plus a long hold-off on request
	always @(posedge clk) begin : drive_ready
		int hold_left;
		bit [31:0] rx_cycle;
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			case (rx_cycle[9:8])
				2'd0: begin
					out_ready <= 1'b1;
				end
				2'd1: begin
					out_ready <= ($urandom_range(0, 1) == 0);
				end
				2'd2: begin
					out_ready <= (rx_cycle[1:0] == 2'd0);
				end
				default: begin
					out_ready <= ($urandom_range(0, 9) != 0);
				end
			endcase
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		center_t want;
		if (arst_n === 1'b1 && out_valid && out_ready) begin
			if (pending_centers.size() == 0) begin
				$error("result transfer with no selection closed");
				errors++;
			end else begin
				want = pending_centers.pop_front();
				check_field("center_x", int'($signed(want.x)), int'(center_x));
				check_field("center_y", int'($signed(want.y)), int'(center_y));
				check_field("center_z", int'($signed(want.z)), int'(center_z));
				check_field("result_status", int'(want.status), int'(result_status));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		row_t plan[$];
		int sent;
		bit held;
		bit paused;
		bit paused_again;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		has_atom <= 1'b0;
		atom_mass <= '0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		last_atom <= 1'b0;
		out_ready <= 1'b0;
		mass_sum = '0;
		moment_x = '0;
		moment_y = '0;
		moment_z = '0;
		atoms_in_sel = 1'b0;
		errors = 0;
		burst_left = 0;
		steady = 1'b0;
		hold_request = 1'b0;
		idle_cycles = 0;

		// empty selections, one with junk atom data
		plan.push_back(plan_row(make_atom(1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000,
			1'b1), BY_VALUE, '0, '0, '0, coma_pkg::STATUS_EMPTY));
		plan.push_back(plan_row(make_atom(1'b0, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h555555,
			1'b1), BY_VALUE, '0, '0, '0, coma_pkg::STATUS_EMPTY));
		// single atoms land on their own position
		plan.push_back(plan_row(make_atom(1'b1, 16'h0100, 24'h7FFFFF, 24'h800000, 24'h000000,
			1'b1), BY_VALUE, 24'h7FFFFF, 24'h800000, 24'h000000, coma_pkg::STATUS_OK));
		plan.push_back(plan_row(make_atom(1'b1, 16'hFFFF, 24'hFFFFFF, 24'h000001, 24'h800000,
			1'b1), BY_VALUE, 24'hFFFFFF, 24'h000001, 24'h800000, coma_pkg::STATUS_OK));
		plan.push_back(plan_row(make_atom(1'b1, 16'hAAAA, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
			1'b1), BY_VALUE, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, coma_pkg::STATUS_OK));
		plan.push_back(plan_row(make_atom(1'b1, 16'h5555, 24'h555555, 24'hAAAAAA, 24'h7FFFFF,
			1'b1), BY_VALUE, 24'h555555, 24'hAAAAAA, 24'h7FFFFF, coma_pkg::STATUS_OK));
		// zero total mass
		plan.push_back(plan_row(make_atom(1'b1, 16'h0000, 24'h123456, 24'h800000, 24'h7FFFFF,
			1'b1), BY_VALUE, '0, '0, '0, coma_pkg::STATUS_ZERO_MASS));
		plan.push_back(plan_row(make_atom(1'b1, 16'h0000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			1'b0)));
		plan.push_back(plan_row(make_atom(1'b1, 16'h0000, 24'h800000, 24'h800000, 24'h800000,
			1'b1), BY_VALUE, '0, '0, '0, coma_pkg::STATUS_ZERO_MASS));
		// rounding ties go away from zero, then rounding with a total mass of three
		plan.push_back(plan_row(make_atom(1'b1, 16'h0001, 24'h000000, 24'h000000, 24'h000000,
			1'b0)));
		plan.push_back(plan_row(make_atom(1'b1, 16'h0001, 24'h000001, 24'hFFFFFF, 24'h000003,
			1'b1), BY_VALUE, 24'h000001, 24'hFFFFFF, 24'h000002, coma_pkg::STATUS_OK));
		plan.push_back(plan_row(make_atom(1'b1, 16'h0001, 24'h000000, 24'h000000, 24'h000000,
			1'b0)));
		plan.push_back(plan_row(make_atom(1'b1, 16'h0002, 24'h000001, 24'hFFFFFF, 24'h400000,
			1'b1)));
		// ignored items inside a selection, closed by an item with no atom
		plan.push_back(plan_row(make_atom(1'b1, 16'h0180, 24'h000100, 24'hFFF000, 24'h012345,
			1'b0)));
		plan.push_back(plan_row(make_atom(1'b0, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			1'b0)));
		plan.push_back(plan_row(make_atom(1'b1, 16'h0080, 24'hFFFF00, 24'h000800, 24'hFEDCBA,
			1'b0)));
		plan.push_back(plan_row(make_atom(1'b0, 16'hFFFF, 24'h800000, 24'h800000, 24'h800000,
			1'b1)));
		// massless atom ahead of a real one
		plan.push_back(plan_row(make_atom(1'b1, 16'h0000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			1'b0)));
		plan.push_back(plan_row(make_atom(1'b1, 16'h0200, 24'hFFEC78, 24'h001388, 24'h000000,
			1'b1)));
		// heaviest atoms at opposite extremes
		plan.push_back(plan_row(make_atom(1'b1, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
			1'b0)));
		plan.push_back(plan_row(make_atom(1'b1, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h800000,
			1'b0)));
		plan.push_back(plan_row(make_atom(1'b1, 16'hFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
			1'b1)));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_atom(plan[i].atom, plan[i].how, plan[i].want);

		// long back-to-back selection of heavy atoms with x and y at the extremes
		steady = 1'b1;
		for (int i = 0; i < LONG_SEL_ATOMS; i++)
			send_atom(make_atom(1'b1, 16'hFFFF, 24'h7FFFFF, 24'h800000,
				coma_pkg::POS_W'($urandom), i == LONG_SEL_ATOMS - 1));
		wait_for_results();

		sent = 0;
		held = 1'b0;
		paused = 1'b0;
		paused_again = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= 600 && !held) begin
				held = 1'b1;
				hold_request = 1'b1;
			end
			if (sent >= 1200 && !paused) begin
				paused = 1'b1;
				wait_for_results();
			end
			if (sent >= 1600 && !paused_again) begin
				paused_again = 1'b1;
				wait_for_results();
			end
			steady = ($urandom_range(0, 5) == 0);
			random_selection(sent);
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
